// ===== rtl/laop_pkg.sv =====
// Package for the liveness arena offset planner.
// Holds sizes, the sequencer state type and the table entry record.
// No dependencies.
package laop_pkg;

	localparam int MAX_BUFFERS = 64;
	localparam int ALIGN_BYTES = 64;

	localparam int IDX_W    = $clog2(MAX_BUFFERS);
	localparam int CNT_W    = $clog2(MAX_BUFFERS + 1);
	localparam int OUT_IDX_W = 6;
	localparam int BYTES_W  = 24;
	localparam int SZ_W     = BYTES_W + 1;
	localparam int OFS_W    = 31;
	localparam int CAND_W   = OFS_W + 1;
	localparam int STEP_W   = 8;

	localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};
	localparam logic [SZ_W-1:0] ALIGN_LOW = SZ_W'(ALIGN_BYTES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_VIEW_RD,
		ST_VIEW_GET,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [OFS_W-1:0]  offset;
		logic [OFS_W-1:0]  end_ofs;
		logic [STEP_W-1:0] first;
		logic [STEP_W-1:0] last;
		logic              is_view;
	} entry_t;

endpackage

// ===== rtl/liveness_arena_offset_planner_core.sv =====
// Liveness arena offset planner: first-fit placement over a 64-entry table.
// Depends on laop_pkg (sizes, state_t, entry_t).
//
// Usage: drive the buffer word on start_plan, buffer_bytes, first_step,
// last_step, is_view and view_target and raise start while busy is low; the
// word is taken at that edge and busy rises. The result word appears on
// placed_offset, arena_size, buffer_index, bad_view and table_full for one
// cycle marked by done; the receiver cannot stall, so it must take it then.
// Busy falls in the done cycle, so a new word may be started at once.
// A full-table or bad alias word goes straight to WRITE and then done; a
// valid alias first reads its target in VIEW_RD and VIEW_GET. A placed
// buffer scans the table entries, restarts included: every collision moves
// the candidate and restarts the scan from entry zero. Each entry read goes
// through SCAN and CHECK and the single registered read port of the entry
// table, feeding one shared overlap comparator.
// Reset clears the entry count, arena end and sequencer; table contents are
// left as they are and only entries below the count are ever used.
module liveness_arena_offset_planner_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               start_plan,
	input  logic [laop_pkg::BYTES_W-1:0]       buffer_bytes,
	input  logic [laop_pkg::STEP_W-1:0]        first_step,
	input  logic [laop_pkg::STEP_W-1:0]        last_step,
	input  logic                               is_view,
	input  logic [laop_pkg::OUT_IDX_W-1:0]     view_target,
	output logic                               done,
	output logic [laop_pkg::OFS_W-1:0]         placed_offset,
	output logic [laop_pkg::OFS_W-1:0]         arena_size,
	output logic [laop_pkg::OUT_IDX_W-1:0]     buffer_index,
	output logic                               bad_view,
	output logic                               table_full
);

	laop_pkg::state_t state_q, state_nxt;

	laop_pkg::entry_t mem [laop_pkg::MAX_BUFFERS];
	laop_pkg::entry_t rd_q;
	laop_pkg::entry_t wr_entry;
	logic [laop_pkg::IDX_W-1:0] rd_addr;
	logic mem_we;

	logic [laop_pkg::CNT_W-1:0]   count_q;
	logic [laop_pkg::CNT_W-1:0]   count_eff;
	logic [laop_pkg::CNT_W-1:0]   j_q;
	logic [laop_pkg::OFS_W-1:0]   arena_q;
	logic [laop_pkg::OFS_W-1:0]   arena_nxt;
	logic [laop_pkg::CAND_W-1:0]  cand_q;
	logic [laop_pkg::CAND_W-1:0]  cand_end_q;
	logic [laop_pkg::OFS_W-1:0]   off_sat;
	logic [laop_pkg::OFS_W-1:0]   end_sat;
	logic [laop_pkg::SZ_W-1:0]    size_in;
	logic [laop_pkg::SZ_W-1:0]    size_q;
	logic [laop_pkg::STEP_W-1:0]  first_q;
	logic [laop_pkg::STEP_W-1:0]  last_q;
	logic                         view_q;
	logic [laop_pkg::OUT_IDX_W-1:0] target_q;
	logic                         full_q;
	logic                         bad_q;
	logic                         accept;
	logic                         full_in;
	logic                         bad_in;
	logic                         meet;
	logic                         hit;

	logic                            done_q;
	logic [laop_pkg::OFS_W-1:0]      placed_offset_q;
	logic [laop_pkg::OFS_W-1:0]      arena_size_q;
	logic [laop_pkg::OUT_IDX_W-1:0]  buffer_index_q;
	logic                            bad_view_q;
	logic                            table_full_q;

	assign busy   = (state_q != laop_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign size_in   = ({1'b0, buffer_bytes} + laop_pkg::ALIGN_LOW) & ~laop_pkg::ALIGN_LOW;
	assign count_eff = start_plan ? '0 : count_q;
	assign full_in   = !start_plan && (count_q >= laop_pkg::CNT_W'(laop_pkg::MAX_BUFFERS));
	assign bad_in    = is_view && (laop_pkg::CNT_W'(view_target) >= count_eff);

	assign meet = !((last_q < rd_q.first) || (rd_q.last < first_q));
	assign hit  = !rd_q.is_view && meet
		&& (cand_q < {1'b0, rd_q.end_ofs})
		&& (cand_end_q > {1'b0, rd_q.offset});

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			laop_pkg::ST_IDLE: begin
				if (start) begin
					if (full_in || bad_in)
						state_nxt = laop_pkg::ST_WRITE;
					else if (is_view)
						state_nxt = laop_pkg::ST_VIEW_RD;
					else
						state_nxt = laop_pkg::ST_SCAN;
				end
			end
			laop_pkg::ST_SCAN: begin
				if (j_q == count_q)
					state_nxt = laop_pkg::ST_WRITE;
				else
					state_nxt = laop_pkg::ST_CHECK;
			end
			laop_pkg::ST_CHECK:    state_nxt = laop_pkg::ST_SCAN;
			laop_pkg::ST_VIEW_RD:  state_nxt = laop_pkg::ST_VIEW_GET;
			laop_pkg::ST_VIEW_GET: state_nxt = laop_pkg::ST_WRITE;
			laop_pkg::ST_WRITE:    state_nxt = laop_pkg::ST_IDLE;
			default:               state_nxt = laop_pkg::ST_IDLE;
		endcase
	end

	// table port and write-back values
	always_comb begin
		off_sat   = (cand_q > {1'b0, laop_pkg::OFS_MAX}) ? laop_pkg::OFS_MAX
			: cand_q[laop_pkg::OFS_W-1:0];
		end_sat   = (cand_end_q > {1'b0, laop_pkg::OFS_MAX}) ? laop_pkg::OFS_MAX
			: cand_end_q[laop_pkg::OFS_W-1:0];
		arena_nxt = (!view_q && (end_sat > arena_q)) ? end_sat : arena_q;
		wr_entry.offset  = off_sat;
		wr_entry.end_ofs = end_sat;
		wr_entry.first   = first_q;
		wr_entry.last    = last_q;
		wr_entry.is_view = view_q;
		mem_we  = 1'b0;
		rd_addr = j_q[laop_pkg::IDX_W-1:0];
		case (state_q)
			laop_pkg::ST_VIEW_RD: rd_addr = laop_pkg::IDX_W'(target_q);
			laop_pkg::ST_WRITE:   mem_we  = !full_q;
			default:              rd_addr = j_q[laop_pkg::IDX_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (mem_we)
			mem[count_q[laop_pkg::IDX_W-1:0]] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= laop_pkg::ST_IDLE;
			count_q <= '0;
			arena_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == laop_pkg::ST_WRITE);
			if (accept && start_plan) begin
				count_q <= '0;
				arena_q <= '0;
			end else if (state_q == laop_pkg::ST_WRITE && !full_q) begin
				count_q <= count_q + 1'b1;
				arena_q <= arena_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q     <= size_in;
			first_q    <= first_step;
			last_q     <= last_step;
			view_q     <= is_view;
			target_q   <= view_target;
			full_q     <= full_in;
			bad_q      <= bad_in;
			j_q        <= '0;
			cand_q     <= '0;
			cand_end_q <= laop_pkg::CAND_W'(size_in);
		end else begin
			case (state_q)
				laop_pkg::ST_CHECK: begin
					if (hit) begin
						j_q        <= '0;
						cand_q     <= {1'b0, rd_q.end_ofs};
						cand_end_q <= {1'b0, rd_q.end_ofs} + laop_pkg::CAND_W'(size_q);
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				laop_pkg::ST_VIEW_GET: cand_q <= {1'b0, rd_q.offset};
				default: j_q <= j_q;
			endcase
		end
		if (state_q == laop_pkg::ST_WRITE) begin
			placed_offset_q <= full_q ? '0 : off_sat;
			arena_size_q    <= full_q ? arena_q : arena_nxt;
			buffer_index_q  <= full_q ? '0 : count_q[laop_pkg::OUT_IDX_W-1:0];
			bad_view_q      <= bad_q && !full_q;
			table_full_q    <= full_q;
		end
	end

	assign done          = done_q;
	assign placed_offset = placed_offset_q;
	assign arena_size    = arena_size_q;
	assign buffer_index  = buffer_index_q;
	assign bad_view      = bad_view_q;
	assign table_full    = table_full_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepting a word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= laop_pkg::CNT_W'(laop_pkg::MAX_BUFFERS))
		else $error("entry count beyond table depth");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && table_full_q) |-> (placed_offset_q == '0 && !bad_view_q))
		else $error("full-table result carries placement data");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for liveness_arena_offset_planner_core: directed, full-table and random
// plans go in through the start/busy port, and each done word is checked against an in-bench
// first-fit arena model. Depends on laop_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int QUIET_LIMIT = 40000;

	typedef struct {
		bit                            plan;
		bit [laop_pkg::BYTES_W-1:0]    bytes;
		bit [laop_pkg::STEP_W-1:0]     first;
		bit [laop_pkg::STEP_W-1:0]     last;
		bit                            view;
		bit [laop_pkg::OUT_IDX_W-1:0]  target;
	} buf_word_t;

	typedef struct {
		logic [laop_pkg::OFS_W-1:0]     offset;
		logic [laop_pkg::OFS_W-1:0]     arena;
		logic [laop_pkg::OUT_IDX_W-1:0] index;
		logic                           bad;
		logic                           full;
	} placement_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic start_plan = 1'b0;
	logic [laop_pkg::BYTES_W-1:0] buffer_bytes = '0;
	logic [laop_pkg::STEP_W-1:0] first_step = '0;
	logic [laop_pkg::STEP_W-1:0] last_step = '0;
	logic is_view = 1'b0;
	logic [laop_pkg::OUT_IDX_W-1:0] view_target = '0;
	logic done;
	logic [laop_pkg::OFS_W-1:0] placed_offset;
	logic [laop_pkg::OFS_W-1:0] arena_size;
	logic [laop_pkg::OUT_IDX_W-1:0] buffer_index;
	logic bad_view;
	logic table_full;

	// arena model state
	longint unsigned tab_ofs[laop_pkg::MAX_BUFFERS];
	longint unsigned tab_size[laop_pkg::MAX_BUFFERS];
	bit [laop_pkg::STEP_W-1:0] tab_first[laop_pkg::MAX_BUFFERS];
	bit [laop_pkg::STEP_W-1:0] tab_last[laop_pkg::MAX_BUFFERS];
	bit tab_view[laop_pkg::MAX_BUFFERS];
	int unsigned tab_count = 0;
	longint unsigned tab_arena = 0;

	placement_t placement_q[$];
	bit idle_on = 1'b1;
	int unsigned words_sent = 0;
	int unsigned results_checked = 0;
	int unsigned n_bad_alias = 0;
	int unsigned n_full = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	liveness_arena_offset_planner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_plan(start_plan),
		.buffer_bytes(buffer_bytes),
		.first_step(first_step),
		.last_step(last_step),
		.is_view(is_view),
		.view_target(view_target),
		.done(done),
		.placed_offset(placed_offset),
		.arena_size(arena_size),
		.buffer_index(buffer_index),
		.bad_view(bad_view),
		.table_full(table_full)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned sat_ofs(longint unsigned v);
		return (v > longint'(laop_pkg::OFS_MAX)) ? longint'(laop_pkg::OFS_MAX) : v;
	endfunction

	function automatic placement_t place_buffer(buf_word_t w);
		placement_t r;
		longint unsigned sz, cand, js, je;
		int unsigned idx;
		bit moved;
		r = '{offset: '0, arena: '0, index: '0, bad: 1'b0, full: 1'b0};
		sz = ((longint'(w.bytes) + laop_pkg::ALIGN_BYTES - 1) / laop_pkg::ALIGN_BYTES)
			* laop_pkg::ALIGN_BYTES;
		if (w.plan) begin
			tab_count = 0;
			tab_arena = 0;
		end
		if (tab_count >= laop_pkg::MAX_BUFFERS) begin
			r.arena = laop_pkg::OFS_W'(tab_arena);
			r.full = 1'b1;
			return r;
		end
		idx = tab_count;
		cand = 0;
		if (w.view) begin
			if (w.target < idx)
				cand = tab_ofs[w.target];
			else
				r.bad = 1'b1;
		end else begin
			moved = 1'b1;
			while (moved) begin
				moved = 1'b0;
				for (int j = 0; j < idx && !moved; j++) begin
					if (!tab_view[j] && !(w.last < tab_first[j] || tab_last[j] < w.first)) begin
						js = tab_ofs[j];
						je = js + tab_size[j];
						if (cand < je && cand + sz > js) begin
							cand = je;
							moved = 1'b1;
						end
					end
				end
			end
			cand = sat_ofs(cand);
			if (sat_ofs(cand + sz) > tab_arena)
				tab_arena = sat_ofs(cand + sz);
		end
		tab_ofs[idx] = cand;
		tab_size[idx] = sz;
		tab_first[idx] = w.first;
		tab_last[idx] = w.last;
		tab_view[idx] = w.view;
		tab_count = idx + 1;
		r.offset = laop_pkg::OFS_W'(cand);
		r.arena = laop_pkg::OFS_W'(tab_arena);
		r.index = laop_pkg::OUT_IDX_W'(idx);
		return r;
	endfunction

	function automatic buf_word_t mk_word(bit plan, int unsigned bytes, int unsigned f,
			int unsigned l, bit view, int unsigned tgt);
		buf_word_t w;
		w.plan = plan;
		w.bytes = laop_pkg::BYTES_W'(bytes);
		w.first = laop_pkg::STEP_W'(f);
		w.last = laop_pkg::STEP_W'(l);
		w.view = view;
		w.target = laop_pkg::OUT_IDX_W'(tgt);
		return w;
	endfunction

	// hold start high with the word until an edge with busy low takes it
	task automatic send_word(buf_word_t w);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 99) < 16) begin
			gap = $urandom_range(1, 12);
			repeat (gap) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		start_plan <= w.plan;
		buffer_bytes <= w.bytes;
		first_step <= w.first;
		last_step <= w.last;
		is_view <= w.view;
		view_target <= w.target;
		do @(posedge clk); while (busy);
		placement_q.push_back(place_buffer(w));
		words_sent++;
	endtask

	function automatic int unsigned rand_bytes();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 255);
			1, 2, 3, 4, 5: return $urandom_range(1, 8192);
			6, 7: return $urandom_range(0, 1 << 20);
			8: return $urandom_range(0, (1 << laop_pkg::BYTES_W) - 1);
			default: return $urandom_range(0, 64) * laop_pkg::ALIGN_BYTES;
		endcase
	endfunction

	function automatic buf_word_t rand_word(bit plan, int unsigned span);
		int unsigned f, l, cnt;
		f = $urandom_range(0, span);
		l = f + $urandom_range(0, span / 2 + 1);
		if (l > 255)
			l = 255;
		if ($urandom_range(0, 19) == 0) begin
			f = $urandom_range(0, 255);
			l = $urandom_range(0, 255);
		end
		cnt = plan ? 0 : tab_count;
		if ($urandom_range(0, 99) < 20) begin
			if (cnt > 0 && $urandom_range(0, 99) < 80)
				return mk_word(plan, rand_bytes(), f, l, 1'b1, $urandom_range(0, cnt - 1));
			return mk_word(plan, rand_bytes(), f, l, 1'b1, $urandom_range(0, 63));
		end
		return mk_word(plan, rand_bytes(), f, l, 1'b0, $urandom_range(0, 63));
	endfunction

	task automatic test_directed();
		send_word(mk_word(1'b0, 24'hFFFFFF, 0, 255, 1'b0, 0));
		send_word(mk_word(1'b0, 1, 0, 255, 1'b0, 63));
		send_word(mk_word(1'b0, 0, 0, 255, 1'b0, 0));
		send_word(mk_word(1'b0, 65, 10, 20, 1'b0, 0));
		send_word(mk_word(1'b0, 64, 50, 10, 1'b0, 0));
		send_word(mk_word(1'b0, 100, 0, 255, 1'b1, 0));
		send_word(mk_word(1'b0, 100, 0, 255, 1'b1, 5));
		send_word(mk_word(1'b0, 100, 0, 255, 1'b1, 7));
		send_word(mk_word(1'b0, 100, 0, 255, 1'b1, 63));
		send_word(mk_word(1'b1, 4096, 0, 9, 1'b1, 0));
		send_word(mk_word(1'b1, 4096, 0, 9, 1'b0, 0));
		send_word(mk_word(1'b0, 4096, 10, 19, 1'b0, 0));
		send_word(mk_word(1'b0, 64, 9, 10, 1'b0, 0));
		send_word(mk_word(1'b0, 24'h800000, 255, 255, 1'b0, 0));
		send_word(mk_word(1'b0, 24'h7FFFFF, 255, 0, 1'b0, 0));
		send_word(mk_word(1'b0, 0, 0, 0, 1'b0, 0));
		send_word(mk_word(1'b0, 128, 0, 0, 1'b0, 0));
		send_word(mk_word(1'b0, 32, 100, 120, 1'b0, 0));
		send_word(mk_word(1'b0, 32, 110, 115, 1'b1, 9));
		send_word(mk_word(1'b1, 0, 255, 255, 1'b0, 42));
		send_word(mk_word(1'b0, 63, 200, 100, 1'b0, 21));
	endtask

	// fill the table, push past it, then recover with a new plan
	task automatic test_full_table();
		idle_on = 1'b0;
		send_word(rand_word(1'b1, 255));
		while (tab_count < laop_pkg::MAX_BUFFERS)
			send_word(rand_word(1'b0, 255));
		send_word(mk_word(1'b0, 64, 0, 255, 1'b0, 0));
		send_word(mk_word(1'b0, 0, 0, 0, 1'b1, 62));
		send_word(mk_word(1'b0, 24'hFFFFFF, 255, 255, 1'b1, 63));
		send_word(mk_word(1'b1, 64, 0, 255, 1'b0, 0));
		idle_on = 1'b1;
	endtask

	task automatic test_random_plans(int unsigned n_words);
		int unsigned plan_len, span, sent;
		sent = 0;
		while (sent < n_words) begin
			case ($urandom_range(0, 19))
				0, 1: plan_len = $urandom_range(25, 63);
				2: plan_len = $urandom_range(64, 70);
				default: plan_len = $urandom_range(1, 24);
			endcase
			case ($urandom_range(0, 2))
				0: span = 15;
				1: span = 63;
				default: span = 255;
			endcase
			for (int i = 0; i < plan_len && sent < n_words; i++) begin
				send_word(rand_word(i == 0 || $urandom_range(0, 99) < 2, span));
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		placement_t exp_r;
		if (arst_n && done) begin
			if (placement_q.size() == 0) begin
				$display("%0t: unexpected result offset %0d arena %0d", $realtime,
					placed_offset, arena_size);
				errors++;
			end else begin
				exp_r = placement_q.pop_front();
				results_checked++;
				if (exp_r.full)
					n_full++;
				else if (exp_r.bad)
					n_bad_alias++;
				if (placed_offset !== exp_r.offset) begin
					$display("%0t: placed_offset expected %0d actual %0d", $realtime,
						exp_r.offset, placed_offset);
					errors++;
				end
				if (arena_size !== exp_r.arena) begin
					$display("%0t: arena_size expected %0d actual %0d", $realtime,
						exp_r.arena, arena_size);
					errors++;
				end
				if (buffer_index !== exp_r.index) begin
					$display("%0t: buffer_index expected %0d actual %0d", $realtime,
						exp_r.index, buffer_index);
					errors++;
				end
				if (bad_view !== exp_r.bad) begin
					$display("%0t: bad_view expected %0b actual %0b", $realtime,
						exp_r.bad, bad_view);
					errors++;
				end
				if (table_full !== exp_r.full) begin
					$display("%0t: table_full expected %0b actual %0b", $realtime,
						exp_r.full, table_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_plans(1700);
		start <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (placement_q.size() != 0)
			errors++;
		$display("Sent %0d buffer words, checked %0d results", words_sent, results_checked);
		$display("Covered %0d bad aliases and %0d full-table rejects", n_bad_alias, n_full);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/laop_pkg.sv
rtl/liveness_arena_offset_planner_core.sv
dv/tb_top.sv
